### rtl/mlq_pkg.sv
package mlq_pkg;

    typedef enum logic [1:0] {
        MODE_ADD  = 2'd0,
        MODE_PUT  = 2'd1,
        MODE_GET  = 2'd2,
        MODE_TICK = 2'd3
    } mode_t;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BOOSTS     = 1'b1;

    localparam logic [7:0] WAIT_THR_RST   = 8'd5;
    localparam logic [3:0] MAX_BOOSTS_RST = 4'd2;
    localparam logic [7:0] WAIT_MAX       = 8'd255;
    localparam logic [3:0] BOOST_MAX      = 4'd15;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ,
        S_SCAN,
        S_GSEL,
        S_GRD,
        S_GWAIT,
        S_GNRD,
        S_GNWB,
        S_TCHK,
        S_TRD,
        S_TPUSH,
        S_TNEXT,
        S_FIN
    } state_t;

    typedef struct packed {
        logic idle;
        logic load_item;
        logic lvl_inc;
        logic scan_step;
        logic gsel;
        logic set_empty;
        logic slot_dec;
        logic pop_get;
        logic wb_next;
        logic tick_eval;
        logic push;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic  in_valid;
        mode_t req_mode;
        logic  lvl_last;
        logic  found_any;
        logic  cnt_gt1;
        logic  lvl_empty;
        logic  tick_move;
        logic  out_free;
    } stat_t;

endpackage

### rtl/mlq_ifs.sv
interface mlq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] proc_id;
    logic [2:0]  prio;
    logic [3:0]  boost_count;

    modport source (output valid, mode, proc_id, prio, boost_count, input ready);
    modport sink (input valid, mode, proc_id, prio, boost_count, output ready);
endinterface

interface mlq_rsp_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [15:0] out_proc_id;
    logic [2:0]  out_level;
    logic [3:0]  out_boost_count;
    logic [1:0]  status;

    modport source (output valid, valid_res, out_proc_id, out_level, out_boost_count, status,
                    input ready);
    modport sink (input valid, valid_res, out_proc_id, out_level, out_boost_count, status,
                  output ready);
endinterface

### rtl/mlq_ram.sv
module mlq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/mlq_ctrl.sv
module mlq_ctrl
    import mlq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t st,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (st.in_valid)
                begin
                    cmd.load_item = 1'b1;
                    unique case (st.req_mode)
                        MODE_ADD, MODE_PUT: state_next = S_ENQ;
                        MODE_GET:           state_next = S_SCAN;
                        MODE_TICK:          state_next = S_TCHK;
                        default:            state_next = S_TCHK;
                    endcase
                end
            end
            S_ENQ:
            begin
                cmd.push = 1'b1;
                state_next = S_FIN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.lvl_last)
                begin
                    state_next = S_GSEL;
                end
                else
                begin
                    cmd.lvl_inc = 1'b1;
                end
            end
            S_GSEL:
            begin
                cmd.gsel = 1'b1;
                if (st.found_any)
                begin
                    state_next = S_GRD;
                end
                else
                begin
                    cmd.set_empty = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_GRD:
            begin
                cmd.slot_dec = 1'b1;
                state_next = S_GWAIT;
            end
            S_GWAIT:
            begin
                cmd.pop_get = 1'b1;
                state_next = st.cnt_gt1 ? S_GNRD : S_FIN;
            end
            S_GNRD:
            begin
                state_next = S_GNWB;
            end
            S_GNWB:
            begin
                cmd.wb_next = 1'b1;
                state_next = S_FIN;
            end
            S_TCHK:
            begin
                state_next = st.lvl_empty ? S_TNEXT : S_TRD;
            end
            S_TRD:
            begin
                cmd.tick_eval = 1'b1;
                state_next = st.tick_move ? S_TPUSH : S_TNEXT;
            end
            S_TPUSH:
            begin
                cmd.push = 1'b1;
                state_next = S_TNEXT;
            end
            S_TNEXT:
            begin
                if (st.lvl_last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.lvl_inc = 1'b1;
                    state_next = S_TCHK;
                end
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/mlq_dp.sv
module mlq_dp
    import mlq_pkg::*;
#(
    parameter int NUM_LEVELS  = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int PID_BITS    = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    mlq_req_if.sink              req,
    mlq_rsp_if.source            rsp,
    input  cmd_t                 cmd,
    output stat_t                st
);

    localparam int LW   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int SW   = $clog2(NUM_LEVELS + 1);
    localparam int NENT = NUM_LEVELS * QUEUE_DEPTH;
    localparam int AW   = $clog2(NENT);
    localparam int PIDW = (PID_BITS < 16) ? PID_BITS : 16;
    localparam int RW   = PIDW + 12;

    logic [PW-1:0] head_reg  [NUM_LEVELS];
    logic [PW-1:0] head_next [NUM_LEVELS];
    logic [CW-1:0] count_reg  [NUM_LEVELS];
    logic [CW-1:0] count_next [NUM_LEVELS];
    logic [7:0]    total_reg  [NUM_LEVELS];
    logic [7:0]    total_next [NUM_LEVELS];
    logic [SW-1:0] slots_reg  [NUM_LEVELS];
    logic [SW-1:0] slots_next [NUM_LEVELS];

    logic [LW-1:0] lvl_reg, lvl_next;
    logic          fq_reg, fq_next;
    logic [LW-1:0] fql_reg, fql_next;
    logic          fn_reg, fn_next;
    logic [LW-1:0] fnl_reg, fnl_next;
    status_t       status_reg, status_next;
    logic [7:0]    thr_reg, thr_next;
    logic [3:0]    maxb_reg, maxb_next;
    logic          rsp_valid_reg, rsp_valid_next;

    mode_t         mode_reg;
    logic [PIDW-1:0] pid_reg;
    logic [2:0]    prio_reg;
    logic [3:0]    bc_reg;
    logic [PIDW-1:0] e_pid_reg;
    logic [7:0]    e_wait_reg;
    logic [3:0]    e_bc_reg;
    logic          o_vres_reg;
    logic [15:0]   o_pid_reg;
    logic [2:0]    o_lvl_reg;
    logic [3:0]    o_bc_reg;
    status_t       o_status_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [AW-1:0] haddr;
    logic [RW-1:0] rdata;
    logic [PIDW-1:0] r_pid;
    logic [7:0]    r_wait;
    logic [3:0]    r_boosts;

    logic [PW-1:0] head_inc;
    logic [8:0]    wait_sum;
    logic [7:0]    wait_sat;
    logic [LW-1:0] up_lvl;
    logic          up_full;
    logic          tick_elig;
    logic          tick_dec;
    logic [7:0]    tick_w1;
    logic          tick_want;
    logic          tick_move;
    logic          is_tick;
    logic          prio_ok;
    logic [LW-1:0] plvl;
    logic          push_ok;
    logic [PW:0]   tail_sum;
    logic [PW-1:0] tail_pos;
    logic [AW-1:0] paddr;
    logic [PIDW-1:0] push_pid;
    logic [3:0]    push_bc;
    logic [7:0]    push_wait;
    logic          got;

    function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] l, input logic [PW-1:0] p);
        return AW'(l) * AW'(QUEUE_DEPTH) + AW'(p);
    endfunction

    mlq_ram #(
        .WIDTH (RW),
        .DEPTH (NENT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (haddr),
        .rdata (rdata)
    );

    assign haddr    = addr_of(lvl_reg, head_reg[lvl_reg]);
    assign r_pid    = rdata[RW-1 -: PIDW];
    assign r_wait   = rdata[11:4];
    assign r_boosts = rdata[3:0];

    assign head_inc = (head_reg[lvl_reg] == PW'(QUEUE_DEPTH - 1)) ? '0
                      : head_reg[lvl_reg] + 1'b1;
    assign wait_sum = {1'b0, r_wait} + {1'b0, e_wait_reg};
    assign wait_sat = wait_sum[8] ? WAIT_MAX : wait_sum[7:0];

    assign up_lvl    = (lvl_reg == '0) ? '0 : lvl_reg - 1'b1;
    assign up_full   = count_reg[up_lvl] >= CW'(QUEUE_DEPTH);
    assign tick_elig = r_boosts < maxb_reg;
    assign tick_dec  = tick_elig && (total_reg[lvl_reg] != '0) && (r_wait != '0);
    assign tick_w1   = tick_dec ? r_wait - 1'b1 : r_wait;
    assign tick_want = tick_elig && (tick_w1 == '0) && (lvl_reg != '0);
    assign tick_move = tick_want && !up_full;

    assign is_tick  = (mode_reg == MODE_TICK);
    assign prio_ok  = 32'(prio_reg) < NUM_LEVELS;
    assign plvl     = is_tick ? up_lvl : (prio_ok ? LW'(prio_reg) : '0);
    assign push_ok  = is_tick || (prio_ok && (count_reg[plvl] < CW'(QUEUE_DEPTH)));
    assign tail_sum = (PW + 1)'(head_reg[plvl]) + (PW + 1)'(count_reg[plvl]);
    assign tail_pos = (tail_sum >= (PW + 1)'(QUEUE_DEPTH))
                      ? PW'(tail_sum - (PW + 1)'(QUEUE_DEPTH)) : PW'(tail_sum);
    assign paddr    = addr_of(plvl, tail_pos);
    assign push_pid = is_tick ? e_pid_reg : pid_reg;
    assign push_bc  = is_tick ? ((e_bc_reg == BOOST_MAX) ? BOOST_MAX : e_bc_reg + 1'b1)
                      : ((mode_reg == MODE_ADD) ? bc_reg : 4'd0);
    assign push_wait = (thr_reg > total_reg[plvl]) ? thr_reg - total_reg[plvl] : 8'd0;

    assign got = (mode_reg == MODE_GET) && (status_reg == ST_OK);

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        slots_next     = slots_reg;
        lvl_next       = lvl_reg;
        fq_next        = fq_reg;
        fql_next       = fql_reg;
        fn_next        = fn_reg;
        fnl_next       = fnl_reg;
        status_next    = status_reg;
        thr_next       = thr_reg;
        maxb_next      = maxb_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        ram_we         = 1'b0;
        ram_waddr      = haddr;
        ram_wdata      = {r_pid, wait_sat, r_boosts};

        if (cfg_we)
        begin
            if (cfg_index == CFG_WAIT_THRESHOLD)
            begin
                thr_next = cfg_data;
            end
            else
            begin
                maxb_next = cfg_data[3:0];
            end
        end

        if (cmd.load_item)
        begin
            lvl_next    = '0;
            fq_next     = 1'b0;
            fn_next     = 1'b0;
            status_next = ST_OK;
        end

        if (cmd.scan_step)
        begin
            if (!fq_reg && (count_reg[lvl_reg] != '0) && (slots_reg[lvl_reg] != '0))
            begin
                fq_next  = 1'b1;
                fql_next = lvl_reg;
            end
            if (!fn_reg && (count_reg[lvl_reg] != '0))
            begin
                fn_next  = 1'b1;
                fnl_next = lvl_reg;
            end
        end

        if (cmd.lvl_inc)
        begin
            lvl_next = lvl_reg + 1'b1;
        end

        if (cmd.gsel)
        begin
            if (fq_reg)
            begin
                lvl_next = fql_reg;
            end
            else
            begin
                for (int i = 0; i < NUM_LEVELS; i++)
                begin
                    slots_next[i] = SW'(NUM_LEVELS - i);
                end
                lvl_next = fnl_reg;
            end
        end

        if (cmd.set_empty)
        begin
            status_next = ST_EMPTY;
        end

        if (cmd.slot_dec)
        begin
            slots_next[lvl_reg] = slots_reg[lvl_reg] - 1'b1;
        end

        if (cmd.tick_eval)
        begin
            if (tick_dec)
            begin
                total_next[lvl_reg] = total_reg[lvl_reg] - 1'b1;
            end
            if (tick_want && up_full)
            begin
                status_next = ST_FULL;
            end
            if (tick_dec && !tick_move)
            begin
                ram_we    = 1'b1;
                ram_wdata = {r_pid, tick_w1, r_boosts};
            end
        end

        if (cmd.pop_get || (cmd.tick_eval && tick_move))
        begin
            head_next[lvl_reg]  = head_inc;
            count_next[lvl_reg] = count_reg[lvl_reg] - 1'b1;
            if (count_reg[lvl_reg] == CW'(1))
            begin
                total_next[lvl_reg] = '0;
            end
        end

        if (cmd.wb_next)
        begin
            ram_we = 1'b1;
        end

        if (cmd.push)
        begin
            if (push_ok)
            begin
                ram_we           = 1'b1;
                ram_waddr        = paddr;
                ram_wdata        = {push_pid, push_wait, push_bc};
                total_next[plvl] = thr_reg;
                count_next[plvl] = count_reg[plvl] + 1'b1;
            end
            else
            begin
                status_next = ST_FULL;
            end
        end

        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
                total_reg[i] <= '0;
                slots_reg[i] <= SW'(NUM_LEVELS - i);
            end
            lvl_reg       <= '0;
            fq_reg        <= 1'b0;
            fql_reg       <= '0;
            fn_reg        <= 1'b0;
            fnl_reg       <= '0;
            status_reg    <= ST_OK;
            thr_reg       <= WAIT_THR_RST;
            maxb_reg      <= MAX_BOOSTS_RST;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            slots_reg     <= slots_next;
            lvl_reg       <= lvl_next;
            fq_reg        <= fq_next;
            fql_reg       <= fql_next;
            fn_reg        <= fn_next;
            fnl_reg       <= fnl_next;
            status_reg    <= status_next;
            thr_reg       <= thr_next;
            maxb_reg      <= maxb_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg <= mode_t'(req.mode);
            pid_reg  <= req.proc_id[PIDW-1:0];
            prio_reg <= req.prio;
            bc_reg   <= req.boost_count;
        end
        if (cmd.pop_get || (cmd.tick_eval && tick_move))
        begin
            e_pid_reg  <= r_pid;
            e_wait_reg <= r_wait;
            e_bc_reg   <= r_boosts;
        end
        if (cmd.out_load)
        begin
            o_vres_reg   <= got;
            o_pid_reg    <= got ? 16'(e_pid_reg) : 16'd0;
            o_lvl_reg    <= got ? 3'(lvl_reg) : 3'd0;
            o_bc_reg     <= got ? e_bc_reg : 4'd0;
            o_status_reg <= status_reg;
        end
    end

    assign req.ready           = cmd.idle;
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.valid_res       = o_vres_reg;
    assign rsp.out_proc_id     = o_pid_reg;
    assign rsp.out_level       = o_lvl_reg;
    assign rsp.out_boost_count = o_bc_reg;
    assign rsp.status          = o_status_reg;

    assign st.in_valid  = req.valid;
    assign st.req_mode  = mode_t'(req.mode);
    assign st.lvl_last  = (lvl_reg == LW'(NUM_LEVELS - 1));
    assign st.found_any = fq_reg || fn_reg;
    assign st.cnt_gt1   = count_reg[lvl_reg] > CW'(1);
    assign st.lvl_empty = (count_reg[lvl_reg] == '0);
    assign st.tick_move = tick_move;
    assign st.out_free  = !rsp_valid_reg || rsp.ready;

endmodule

### rtl/mlq_scheduler_with_aging.sv
// Multilevel ready-queue scheduler with aging, taking one item at a time. A get and an aging
// tick both walk the levels one by one, reading entries through the single read port of the
// entry memory. Every item returns exactly one result item, which waits in an output register.
module mlq_scheduler_with_aging
    import mlq_pkg::*;
#(
    parameter int NUM_LEVELS  = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int PID_BITS    = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    mlq_req_if.sink              req,
    mlq_rsp_if.source            rsp
);

    cmd_t  cmd;
    stat_t st;

    mlq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    mlq_dp #(
        .NUM_LEVELS  (NUM_LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PID_BITS    (PID_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .st        (st)
    );

`ifndef NO_ASSERTIONS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("item accepted while another is in progress");

    a_result_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.valid_res) |-> (rsp.status == ST_OK))
        else $error("returned process carries an error status");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(cmd.out_load))
        else $error("result appeared without being loaded");
`endif

endmodule
